FILE: src/cbm_pkg.sv
`default_nettype none
package cbm_pkg;

    // Item kinds as classified by the front part
    localparam logic [2:0] K_NONE  = 3'd0;  // no effect, answers target none
    localparam logic [2:0] K_WRITE = 3'd1;  // mapper register write
    localparam logic [2:0] K_PRG   = 3'd2;  // program ROM read
    localparam logic [2:0] K_PAT   = 3'd3;  // pattern fetch
    localparam logic [2:0] K_NT    = 3'd4;  // nametable fetch

    // Input commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_PRG   = 2'd1;
    localparam logic [1:0] CMD_PAT   = 2'd2;
    localparam logic [1:0] CMD_NT    = 2'd3;

    // Result targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PRG  = 2'd1;
    localparam logic [1:0] TGT_PAT  = 2'd2;
    localparam logic [1:0] TGT_RAM  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_BANKS = 2'd0;
    localparam logic [1:0] CFG_CHR_PAGES = 2'd1;
    localparam logic [1:0] CFG_HEADER    = 2'd2;

    // Mapper register selects, address bits 14..12 of a write at $8000 and up
    localparam logic [2:0] REG_PAT0   = 3'd0;
    localparam logic [2:0] REG_PAT1   = 3'd1;
    localparam logic [2:0] REG_PAT2   = 3'd2;
    localparam logic [2:0] REG_PAT3   = 3'd3;
    localparam logic [2:0] REG_NT0    = 3'd4;
    localparam logic [2:0] REG_NT1    = 3'd5;
    localparam logic [2:0] REG_MIRROR = 3'd6;
    localparam logic [2:0] REG_PRG    = 3'd7;

    // Mirroring modes
    localparam logic [1:0] MIR_HORZ  = 2'd0;
    localparam logic [1:0] MIR_VERT  = 2'd1;
    localparam logic [1:0] MIR_ONE_0 = 2'd2;
    localparam logic [1:0] MIR_ONE_1 = 2'd3;

    // Bank number reduction: bits of the dividend, one per cycle
    localparam int DIV_BITS = 9;
    localparam int CNT_W    = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

endpackage
`default_nettype wire

FILE: src/cbm_front.sv
`default_nettype none
module cbm_front
    import cbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data,
    output logic             o_push,
    input  wire logic        i_q_ready,
    output t_item            o_item
);

    logic        r_valid;
    t_item       r_item;
    logic [2:0]  w_kind;
    logic        w_take;

    always_comb begin
        case (i_command)
            CMD_WRITE: w_kind = i_address[15] ? K_WRITE : K_NONE;
            CMD_PRG:   w_kind = i_address[15] ? K_PRG : K_NONE;
            CMD_PAT:   w_kind = !i_address[13] ? K_PAT : K_NONE;
            CMD_NT:    w_kind = (i_address[13] && (i_address[13:8] != 6'h3F)) ? K_NT : K_NONE;
            default:   w_kind = K_NONE;
        endcase
    end

    assign o_push  = r_valid && i_q_ready;
    assign o_ready = !r_valid || i_q_ready;
    assign w_take  = i_valid && o_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind    <= w_kind;
            r_item.address <= i_address;
            r_item.data    <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: src/cbm_queue.sv
`default_nettype none
module cbm_queue
    import cbm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/cbm_back.sv
`default_nettype none
module cbm_back
    import cbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_q_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_target,
    output logic [17:0]      o_rom_address
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [7:0]  r_pat_bank [4];
    logic [6:0]  r_nt_page [2];
    logic [3:0]  r_prg_bank;
    logic        r_nt_rom;
    logic [1:0]  r_mirror;
    logic [4:0]  r_prg_cnt;
    logic [8:0]  r_chr_cnt;

    logic [8:0]       r_dvd;
    logic [8:0]       r_dvs;
    logic [7:0]       r_rem;
    logic [CNT_W-1:0] r_step;
    logic [1:0]       r_tgt;
    logic [13:0]      r_low;

    logic        r_out_valid;
    logic [1:0]  r_out_tgt;
    logic [17:0] r_out_addr;

    logic [4:0]  w_prg_eff;
    logic [8:0]  w_chr_eff;
    logic        w_out_free;
    logic        w_sel;
    logic [8:0]  w_trial;
    logic        w_fits;
    logic [8:0]  w_diff;
    logic        w_load;
    logic [1:0]  w_load_tgt;
    logic [17:0] w_load_addr;
    logic [2:0]  w_reg;

    assign w_prg_eff = (r_prg_cnt == 5'd0) ? 5'd1 : ((r_prg_cnt > 5'd16) ? 5'd16 : r_prg_cnt);
    assign w_chr_eff = ((r_chr_cnt == 9'd0) || (r_chr_cnt > 9'd256)) ? 9'd256 : r_chr_cnt;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == ST_IDLE) && i_q_valid && w_out_free;
    assign w_reg      = i_item.address[14:12];

    always_comb begin
        case (r_mirror)
            MIR_HORZ:  w_sel = i_item.address[11];
            MIR_VERT:  w_sel = i_item.address[10];
            MIR_ONE_0: w_sel = 1'b0;
            MIR_ONE_1: w_sel = 1'b1;
            default:   w_sel = 1'b0;
        endcase
    end

    // One restoring remainder step per cycle
    assign w_trial = {r_rem, r_dvd[8]};
    assign w_fits  = (w_trial >= r_dvs);
    assign w_diff  = w_trial - r_dvs;

    // Results that need no reduction go straight to the output register; reduced results load it from the done state
    always_comb begin
        w_load      = 1'b0;
        w_load_tgt  = TGT_NONE;
        w_load_addr = '0;
        if (o_pop) begin
            case (i_item.kind)
                K_PRG, K_PAT: begin
                    w_load = 1'b0;
                end
                K_NT: begin
                    if (!r_nt_rom) begin
                        w_load      = 1'b1;
                        w_load_tgt  = TGT_RAM;
                        w_load_addr = {7'd0, w_sel, i_item.address[9:0]};
                    end
                end
                default: begin
                    w_load = 1'b1;
                end
            endcase
        end else if ((r_state == ST_DONE) && w_out_free) begin
            w_load     = 1'b1;
            w_load_tgt = r_tgt;
            if (r_tgt == TGT_PRG) begin
                w_load_addr = {r_rem[3:0], r_low};
            end else begin
                w_load_addr = {r_rem, r_low[9:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && ((i_item.kind == K_PRG) || (i_item.kind == K_PAT)
                            || ((i_item.kind == K_NT) && r_nt_rom))) begin
                        r_state <= ST_DIV;
                        r_step  <= '0;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == CNT_W'(DIV_BITS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Divider operands and the address pieces carried alongside
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem <= '0;
            r_low <= i_item.address[13:0];
            case (i_item.kind)
                K_PRG: begin
                    r_tgt <= TGT_PRG;
                    r_dvs <= {4'd0, w_prg_eff};
                    r_dvd <= i_item.address[14] ? {4'd0, w_prg_eff - 5'd1}
                                                : {5'd0, r_prg_bank};
                end
                K_PAT: begin
                    r_tgt <= TGT_PAT;
                    r_dvs <= w_chr_eff;
                    r_dvd <= {r_pat_bank[i_item.address[12:11]], i_item.address[10]};
                end
                default: begin
                    r_tgt <= TGT_PAT;
                    r_dvs <= w_chr_eff;
                    r_dvd <= {2'd0, r_nt_page[w_sel]};
                end
            endcase
        end else if (r_state == ST_DIV) begin
            r_dvd <= {r_dvd[7:0], 1'b0};
            r_rem <= w_fits ? w_diff[7:0] : w_trial[7:0];
        end
    end

    // Mapper state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bank[0] <= 8'd0;
            r_pat_bank[1] <= 8'd1;
            r_pat_bank[2] <= 8'd2;
            r_pat_bank[3] <= 8'd3;
            r_nt_page[0]  <= '0;
            r_nt_page[1]  <= '0;
            r_prg_bank    <= '0;
            r_nt_rom      <= 1'b0;
            r_mirror      <= MIR_HORZ;
            r_prg_cnt     <= 5'd16;
            r_chr_cnt     <= 9'd256;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PRG_BANKS: r_prg_cnt <= i_cfg_data[4:0];
                    CFG_CHR_PAGES: r_chr_cnt <= i_cfg_data;
                    CFG_HEADER:    r_mirror  <= {1'b0, i_cfg_data[0]};
                    default:       ;
                endcase
            end
            if (o_pop && (i_item.kind == K_WRITE)) begin
                case (w_reg)
                    REG_PAT0: r_pat_bank[0] <= i_item.data;
                    REG_PAT1: r_pat_bank[1] <= i_item.data;
                    REG_PAT2: r_pat_bank[2] <= i_item.data;
                    REG_PAT3: r_pat_bank[3] <= i_item.data;
                    REG_NT0:  r_nt_page[0]  <= i_item.data[6:0];
                    REG_NT1:  r_nt_page[1]  <= i_item.data[6:0];
                    REG_MIRROR: begin
                        r_mirror <= i_item.data[1:0];
                        r_nt_rom <= i_item.data[4];
                    end
                    REG_PRG:  r_prg_bank <= i_item.data[3:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_tgt  <= w_load_tgt;
            r_out_addr <= w_load_addr;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_target      = r_out_tgt;
    assign o_rom_address = r_out_addr;

endmodule
`default_nettype wire

FILE: src/cartridge_bank_mapper.sv
// Cartridge bank mapper: bank switching for a game console cartridge.
// Input stream (s_axis): one item per transfer, a CPU register write or an
// address to translate, with the command in tuser. Output stream (m_axis):
// one result per item, in order: the byte offset in tdata and the target
// memory in tuser.
// Configuration: i_cfg_wr_en, i_cfg_index, i_cfg_data, written while idle.
// Index 0 sets the program bank count, 1 the pattern page count, 2 the
// header mirroring (also reloads the mirroring mode).
// A front stage classifies items and pushes them into a short queue; the
// back part executes them in order and holds the result in an output register.
// Register writes, ignored accesses and console RAM nametable fetches pass
// through the front register and the queue into the output register.
// Program reads, pattern fetches and ROM nametable fetches first have the
// bank number reduced modulo the bank count by a shared remainder unit, one
// bit per cycle. Short items flow at one item per cycle while the receiver
// is ready; no item is taken from the queue until a reduction has finished.
// Reset (synchronous, active low) restores the mapper registers and counts
// and empties the queue. When the receiver stalls, the result holds, the
// queue fills, and then s_axis_tready drops.
`default_nettype none
module cartridge_bank_mapper
    import cbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // address[15:0], data[23:16]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // rom_address[17:0]
    output logic [1:0]       m_axis_tuser,   // target[1:0]
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);

    logic        w_push;
    logic        w_q_ready;
    t_item       w_front_item;
    logic        w_q_valid;
    logic        w_pop;
    t_item       w_q_item;
    logic [17:0] w_rom_address;

    cbm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_command (s_axis_tuser),
        .i_address (s_axis_tdata[15:0]),
        .i_data    (s_axis_tdata[23:16]),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_item    (w_front_item)
    );

    cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    cbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_target      (m_axis_tuser),
        .o_rom_address (w_rom_address)
    );

    assign m_axis_tdata = {6'd0, w_rom_address};

endmodule
`default_nettype wire

FILE: src/cbm_checker.sv
`default_nettype none
module cbm_checker
    import cbm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == TGT_NONE) |-> (m_axis_tdata == 24'd0))
        else $error("target none with non-zero offset");

    a_ram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == TGT_RAM) |-> (m_axis_tdata[23:11] == 13'd0))
        else $error("console RAM offset beyond 2KB");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready straight after reset");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
